[rtl/srdb_pkg.sv]
package srdb_pkg;

    localparam int SETS_DEF     = 2048;
    localparam int WAYS_DEF     = 16;
    localparam int SIG_BITS_DEF = 4;
    localparam int SET_W        = 11;
    localparam int WAY_W        = 4;
    localparam int ADDR_W       = 48;
    localparam int PERIOD_W     = 5;
    localparam int COUNT_W      = 20;
    localparam int BADDR_W      = 32;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 5'd12;

    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_VICTIM,
        ST_AGE,
        ST_UPDATE,
        ST_DECAY,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic read;
        logic victim_eval;
        logic age_write;
        logic update_write;
        logic decay_step;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_update;
        logic dead_found;
        logic decay_due;
        logic decay_done;
    } status_t;

endpackage

[rtl/srdb_if.sv]
interface srdb_in_if;
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic [srdb_pkg::SET_W-1:0]      set_index;
    logic [srdb_pkg::WAY_W-1:0]      way;
    logic [srdb_pkg::ADDR_W-1:0]     pc;
    logic [srdb_pkg::ADDR_W-1:0]     paddr;
    logic                            hit;
    modport source (output valid, op, set_index, way, pc, paddr, hit, input ready);
    modport sink (input valid, op, set_index, way, pc, paddr, hit, output ready);
endinterface

interface srdb_out_if;
    logic                            valid;
    logic                            ready;
    logic [srdb_pkg::WAY_W-1:0]      victim_way;
    logic                            chosen_as_dead;
    modport source (output valid, victim_way, chosen_as_dead, input ready);
    modport sink (input valid, victim_way, chosen_as_dead, output ready);
endinterface

[rtl/srdb_ctrl.sv]
module srdb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  srdb_pkg::status_t status,
    output srdb_pkg::cmd_t    cmd
);

    srdb_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srdb_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            srdb_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = srdb_pkg::ST_IDLE;
                end
            end
            srdb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = srdb_pkg::ST_READ;
                end
            end
            srdb_pkg::ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = status.is_update ? srdb_pkg::ST_UPDATE : srdb_pkg::ST_VICTIM;
            end
            srdb_pkg::ST_VICTIM:
            begin
                cmd.victim_eval = 1'b1;
                state_next = status.dead_found ? srdb_pkg::ST_OUT : srdb_pkg::ST_AGE;
            end
            srdb_pkg::ST_AGE:
            begin
                cmd.age_write = 1'b1;
                state_next    = srdb_pkg::ST_OUT;
            end
            srdb_pkg::ST_UPDATE:
            begin
                cmd.update_write = 1'b1;
                state_next = status.decay_due ? srdb_pkg::ST_DECAY : srdb_pkg::ST_IDLE;
            end
            srdb_pkg::ST_DECAY:
            begin
                cmd.decay_step = 1'b1;
                if (status.decay_done)
                begin
                    state_next = srdb_pkg::ST_IDLE;
                end
            end
            srdb_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = srdb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srdb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/srdb_datapath.sv]
module srdb_datapath #(
    parameter int SETS     = srdb_pkg::SETS_DEF,
    parameter int WAYS     = srdb_pkg::WAYS_DEF,
    parameter int SIG_BITS = srdb_pkg::SIG_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  srdb_pkg::cmd_t                   cmd,
    output srdb_pkg::status_t                status,
    input  logic                             cfg_we,
    input  logic [srdb_pkg::PERIOD_W-1:0]    cfg_data,
    input  logic                             op,
    input  logic [srdb_pkg::SET_W-1:0]       set_index,
    input  logic [srdb_pkg::WAY_W-1:0]       way,
    input  logic [srdb_pkg::ADDR_W-1:0]      pc,
    input  logic [srdb_pkg::ADDR_W-1:0]      paddr,
    input  logic                             hit,
    output logic [srdb_pkg::WAY_W-1:0]       victim_way,
    output logic                             chosen_as_dead
);

    localparam int SW   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW   = $clog2(WAYS);
    localparam int SIGN = 1 << SIG_BITS;
    localparam int CW   = SW + 1;

    typedef logic [WAYS-1:0][1:0]         pair_row_t;
    typedef logic [WAYS-1:0][SIG_BITS-1:0] sig_row_t;
    typedef logic [SIGN-1:0][1:0]         oc_row_t;

    pair_row_t rrpv_mem [SETS];
    sig_row_t  sig_mem  [SETS];
    oc_row_t   oc_mem   [SETS];
    pair_row_t dead_mem [SETS];
    logic [srdb_pkg::BADDR_W:0] strm_mem [SETS];

    pair_row_t rrpv_rd_reg, dead_rd_reg;
    sig_row_t  sig_rd_reg;
    oc_row_t   oc_rd_reg;
    logic [srdb_pkg::BADDR_W:0] strm_rd_reg;

    logic                            op_reg;
    logic [SW-1:0]                   set_reg;
    logic [WW-1:0]                   way_reg;
    logic [SIG_BITS-1:0]             sig_reg;
    logic [srdb_pkg::BADDR_W-1:0]    baddr_reg;
    logic                            hit_reg;
    logic [srdb_pkg::PERIOD_W-1:0]   period_reg;
    logic [srdb_pkg::COUNT_W-1:0]    count_reg;
    logic [CW-1:0]                   sweep_reg;
    logic                            due_reg;
    logic [WW-1:0]                   vway_reg;
    logic                            vdead_reg;
    logic [SW-1:0]                   sidx;

    logic [srdb_pkg::ADDR_W-1:0] sig_wide;
    logic [srdb_pkg::COUNT_W-1:0] cnt_inc, pmask;
    logic [4:0] plog;
    logic [WAYS-1:0] dead3, rr3;
    logic [1:0] top, inc;
    logic [WW-1:0] dead_w, rr_w;
    pair_row_t aged, rr_new, dd_new, decayed, dead_eff;
    sig_row_t  sg_new;
    oc_row_t   oc_new;
    logic [srdb_pkg::BADDR_W:0] strm_new;
    logic [srdb_pkg::BADDR_W-1:0] prev, delta;
    logic strm_cur;
    logic [SIG_BITS-1:0] osig;
    logic [1:0] c, ins;

    assign sidx     = sweep_reg[SW-1:0];
    assign sig_wide = pc ^ (pc >> 4) ^ (paddr >> 8);

    always_comb
    begin
        plog  = (period_reg > 5'd20) ? 5'd20 : period_reg;
        pmask = srdb_pkg::COUNT_W'((32'd1 << plog) - 32'd1);
        cnt_inc = count_reg + 1'b1;
        dead3 = '0;
        rr3   = '0;
        top   = 2'd0;
        for (int i = 0; i < WAYS; i++)
        begin
            dead3[i] = (dead_rd_reg[i] == 2'd3);
            if (rrpv_rd_reg[i] > top)
            begin
                top = rrpv_rd_reg[i];
            end
        end
        inc = 2'd3 - top;
        for (int i = 0; i < WAYS; i++)
        begin
            aged[i] = rrpv_rd_reg[i] + inc;
            rr3[i]  = (aged[i] == 2'd3);
            decayed[i] = (dead_rd_reg[i] != 2'd0) ? dead_rd_reg[i] - 2'd1 : 2'd0;
        end
        dead_eff = due_reg ? decayed : dead_rd_reg;
        dead_w = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (dead3[i])
            begin
                dead_w = WW'(i);
            end
        end
        rr_w = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (rr3[i])
            begin
                rr_w = WW'(i);
            end
        end

        prev  = strm_rd_reg[srdb_pkg::BADDR_W-1:0];
        delta = baddr_reg - prev;
        strm_cur = strm_rd_reg[srdb_pkg::BADDR_W];
        if (prev != '0 && (delta == 32'd1 || delta == 32'hFFFF_FFFF))
        begin
            strm_cur = 1'b1;
        end
        else if (prev != '0 && delta != '0)
        begin
            strm_cur = 1'b0;
        end
        strm_new = {strm_cur, baddr_reg};

        rr_new = rrpv_rd_reg;
        dd_new = dead_eff;
        sg_new = sig_rd_reg;
        oc_new = oc_rd_reg;
        osig   = sig_rd_reg[way_reg];
        c      = oc_rd_reg[sig_reg];
        ins    = 2'd3;
        if (hit_reg)
        begin
            rr_new[way_reg] = 2'd0;
            dd_new[way_reg] = 2'd0;
            if (oc_rd_reg[osig] != 2'd3)
            begin
                oc_new[osig] = oc_rd_reg[osig] + 2'd1;
            end
        end
        else
        begin
            if (dead_eff[way_reg] == 2'd3 || strm_cur)
            begin
                ins = 2'd3;
            end
            else if (c >= 2'd2)
            begin
                ins = 2'd0;
            end
            else if (c == 2'd1)
            begin
                ins = 2'd2;
            end
            else
            begin
                ins = 2'd3;
            end
            sg_new[way_reg] = sig_reg;
            rr_new[way_reg] = ins;
            if (oc_rd_reg[osig] != 2'd0)
            begin
                oc_new[osig] = oc_rd_reg[osig] - 2'd1;
            end
            if (dead_eff[way_reg] != 2'd3)
            begin
                dd_new[way_reg] = dead_eff[way_reg] + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= srdb_pkg::PERIOD_RESET;
            count_reg  <= '0;
            sweep_reg  <= '0;
            due_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                period_reg <= cfg_data;
            end
            if (cmd.clear_step || cmd.decay_step)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            else if (cmd.update_write)
            begin
                sweep_reg <= '0;
            end
            if (cmd.read && op_reg == srdb_pkg::OP_UPDATE)
            begin
                count_reg <= cnt_inc;
                due_reg   <= ((cnt_inc & pmask) == '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            set_reg   <= SW'(set_index % SETS);
            way_reg   <= WW'(way % WAYS);
            sig_reg   <= sig_wide[SIG_BITS-1:0];
            baddr_reg <= paddr[37:6];
            hit_reg   <= hit;
        end
        if (cmd.read)
        begin
            rrpv_rd_reg <= rrpv_mem[set_reg];
            sig_rd_reg  <= sig_mem[set_reg];
            oc_rd_reg   <= oc_mem[set_reg];
            dead_rd_reg <= dead_mem[set_reg];
            strm_rd_reg <= strm_mem[set_reg];
        end
        if (cmd.victim_eval)
        begin
            vway_reg  <= dead3 != '0 ? dead_w : rr_w;
            vdead_reg <= dead3 != '0;
        end
        if (cmd.clear_step)
        begin
            rrpv_mem[sidx] <= {WAYS{2'd3}};
            sig_mem[sidx]  <= '0;
            oc_mem[sidx]   <= {SIGN{2'd1}};
            dead_mem[sidx] <= '0;
            strm_mem[sidx] <= '0;
        end
        if (cmd.age_write)
        begin
            rrpv_mem[set_reg] <= aged;
        end
        if (cmd.update_write)
        begin
            rrpv_mem[set_reg] <= rr_new;
            sig_mem[set_reg]  <= sg_new;
            oc_mem[set_reg]   <= oc_new;
            strm_mem[set_reg] <= strm_new;
            dead_mem[set_reg] <= dd_new;
        end
        if (cmd.decay_step)
        begin
            dead_rd_reg <= dead_mem[sidx];
            if (sweep_reg != '0 && SW'(sweep_reg - 1'b1) != set_reg)
            begin
                dead_mem[SW'(sweep_reg - 1'b1)] <= decayed;
            end
        end
    end

    assign status.clear_done = (sweep_reg == CW'(SETS - 1));
    assign status.decay_done = (sweep_reg == CW'(SETS));
    assign status.is_update  = (op_reg == srdb_pkg::OP_UPDATE);
    assign status.dead_found = (dead3 != '0);
    assign status.decay_due  = due_reg;
    assign victim_way     = srdb_pkg::WAY_W'(vway_reg);
    assign chosen_as_dead = vdead_reg;

endmodule

[rtl/ship_rrip_dead_block_replacement.sv]
// Dead-block aware SHiP/RRIP replacement policy for a last-level cache.
// Channel in_ch carries requests: op 0 asks for a victim in set_index,
// op 1 reports an access (hit or miss-and-fill) to set_index/way.
// Channel out_ch returns one victim_way/chosen_as_dead per victim request;
// updates return nothing. Both use valid/ready; a transfer happens when
// both are high. One request is in flight at a time.
// Victim request: READ, VICTIM, then OUT when a dead way exists; AGE comes
// between VICTIM and OUT when the set must be aged and its row rewritten.
// Update: READ and UPDATE, plus a DECAY sweep whenever the access count
// hits the decay period, in which every set's dead counters are decremented
// row by row. After reset the block clears all set rows, one row a cycle,
// with in_ch.ready low. decay_period_log2 resets to 12; the user must write
// it via cfg_we/cfg_data only while idle, which the block does not enforce.
// If out_ch.ready is low the result holds and no new request is taken.
// Update note: the decay counts before the update; the accessed row is
// decayed inside the update write and skipped by the sweep that follows.
module ship_rrip_dead_block_replacement #(
    parameter int SETS     = srdb_pkg::SETS_DEF,
    parameter int WAYS     = srdb_pkg::WAYS_DEF,
    parameter int SIG_BITS = srdb_pkg::SIG_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [srdb_pkg::PERIOD_W-1:0] cfg_data,
    srdb_in_if.sink                       in_ch,
    srdb_out_if.source                    out_ch
);

    srdb_pkg::cmd_t    cmd;
    srdb_pkg::status_t status;

    srdb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    srdb_datapath #(
        .SETS     (SETS),
        .WAYS     (WAYS),
        .SIG_BITS (SIG_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .op             (in_ch.op),
        .set_index      (in_ch.set_index),
        .way            (in_ch.way),
        .pc             (in_ch.pc),
        .paddr          (in_ch.paddr),
        .hit            (in_ch.hit),
        .victim_way     (out_ch.victim_way),
        .chosen_as_dead (out_ch.chosen_as_dead)
    );

endmodule

[dv/srdb_victim_checker.sv]
`timescale 1ns / 100ps

module srdb_victim_checker
    import srdb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [PERIOD_W-1:0] cfg_data,
    srdb_in_if                  in_mon,
    srdb_out_if                 out_mon,
    output int                  mismatches,
    output int                  victims_pending
);

    localparam int NSETS  = SETS_DEF;
    localparam int NWAYS  = WAYS_DEF;
    localparam int NSIGS  = 1 << SIG_BITS_DEF;
    localparam int BLOCKS = NSETS * NWAYS;

    typedef struct packed {
        logic [WAY_W-1:0] way;
        logic             dead;
    } victim_t;

    logic [1:0]              rrpv      [BLOCKS];
    logic [SIG_BITS_DEF-1:0] blk_sig   [BLOCKS];
    logic [1:0]              dead_cnt  [BLOCKS];
    logic [1:0]              outcome   [NSETS * NSIGS];
    logic                    streaming [NSETS];
    logic [BADDR_W-1:0]      last_blk  [NSETS];
    logic [COUNT_W-1:0]      accesses;
    logic [PERIOD_W-1:0]     decay_log2;
    victim_t                 victims_due [$];

    function automatic void clear_policy();
        for (int i = 0; i < BLOCKS; i++)
        begin
            rrpv[i]     = 2'd3;
            blk_sig[i]  = '0;
            dead_cnt[i] = 2'd0;
        end
        for (int i = 0; i < NSETS * NSIGS; i++)
            outcome[i] = 2'd1;
        for (int i = 0; i < NSETS; i++)
        begin
            streaming[i] = 1'b0;
            last_blk[i]  = '0;
        end
        accesses   = '0;
        decay_log2 = PERIOD_RESET;
    endfunction

    function automatic victim_t pick_victim(int set);
        int      base;
        int      w;
        logic [1:0] top;
        victim_t v;
        base = set * NWAYS;
        top  = 2'd0;
        for (w = 0; w < NWAYS; w++)
            if (dead_cnt[base + w] == 2'd3)
            begin
                v.way  = w[WAY_W-1:0];
                v.dead = 1'b1;
                return v;
            end
        for (w = 0; w < NWAYS; w++)
            if (rrpv[base + w] > top)
                top = rrpv[base + w];
        for (w = 0; w < NWAYS; w++)
            rrpv[base + w] = rrpv[base + w] + (2'd3 - top);
        for (w = 0; w < NWAYS; w++)
            if (rrpv[base + w] == 2'd3)
                break;
        v.way  = w[WAY_W-1:0];
        v.dead = 1'b0;
        return v;
    endfunction

    function automatic void apply_access(int set, int way, logic [ADDR_W-1:0] pc,
                                         logic [ADDR_W-1:0] paddr, logic hit);
        int                      blk;
        int                      plog;
        logic [BADDR_W-1:0]      baddr;
        logic [BADDR_W-1:0]      delta;
        logic [SIG_BITS_DEF-1:0] sig;
        logic [SIG_BITS_DEF-1:0] old_sig;
        logic [COUNT_W-1:0]      pmask;
        logic [1:0]              c;
        logic [1:0]              depth;
        blk   = set * NWAYS + way;
        baddr = paddr[37:6];
        delta = baddr - last_blk[set];
        sig   = pc[3:0] ^ pc[7:4] ^ paddr[11:8];
        plog  = (decay_log2 > 20) ? 20 : int'(decay_log2);
        pmask = COUNT_W'((64'd1 << plog) - 64'd1);
        accesses = accesses + 1'b1;
        if (last_blk[set] != 0 && (delta == 32'd1 || delta == 32'hFFFF_FFFF))
            streaming[set] = 1'b1;
        else if (last_blk[set] != 0 && delta != 0)
            streaming[set] = 1'b0;
        last_blk[set] = baddr;
        if ((accesses & pmask) == 0)
            for (int i = 0; i < BLOCKS; i++)
                if (dead_cnt[i] != 2'd0)
                    dead_cnt[i] = dead_cnt[i] - 2'd1;
        if (hit)
        begin
            rrpv[blk] = 2'd0;
            if (outcome[set * NSIGS + blk_sig[blk]] != 2'd3)
                outcome[set * NSIGS + blk_sig[blk]] += 2'd1;
            dead_cnt[blk] = 2'd0;
        end
        else
        begin
            old_sig      = blk_sig[blk];
            blk_sig[blk] = sig;
            if (dead_cnt[blk] == 2'd3 || streaming[set])
                depth = 2'd3;
            else
            begin
                c = outcome[set * NSIGS + sig];
                depth = (c >= 2'd2) ? 2'd0 : ((c == 2'd1) ? 2'd2 : 2'd3);
            end
            rrpv[blk] = depth;
            if (outcome[set * NSIGS + old_sig] != 2'd0)
                outcome[set * NSIGS + old_sig] -= 2'd1;
            if (dead_cnt[blk] != 2'd3)
                dead_cnt[blk] = dead_cnt[blk] + 2'd1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_policy();
            victims_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
                decay_log2 = cfg_data;
            if (in_mon.valid && in_mon.ready)
            begin
                if (in_mon.op == OP_VICTIM)
                    victims_due.push_back(pick_victim(int'(in_mon.set_index)));
                else
                    apply_access(int'(in_mon.set_index), int'(in_mon.way), in_mon.pc,
                                 in_mon.paddr, in_mon.hit);
            end
            if (out_mon.valid && out_mon.ready)
            begin
                if (victims_due.size() == 0)
                begin
                    $display("%0t: unexpected victim transfer way %0d dead %0b",
                             $time, out_mon.victim_way, out_mon.chosen_as_dead);
                    mismatches++;
                end
                else if (victims_due[0].way !== out_mon.victim_way ||
                         victims_due[0].dead !== out_mon.chosen_as_dead)
                begin
                    $display("%0t: victim mismatch expected way %0d dead %0b, got way %0d dead %0b",
                             $time, victims_due[0].way, victims_due[0].dead,
                             out_mon.victim_way, out_mon.chosen_as_dead);
                    mismatches++;
                    void'(victims_due.pop_front());
                end
                else
                    void'(victims_due.pop_front());
            end
        end
        victims_pending = victims_due.size();
    end

endmodule

[dv/ship_rrip_dead_block_replacement_test.sv]
`timescale 1ns / 100ps

module ship_rrip_dead_block_replacement_test;
    import srdb_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = SETS_DEF + 64;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [PERIOD_W-1:0] cfg_data;
    int                  mismatches;
    int                  victims_pending;
    int                  cycles;
    logic [ADDR_W-1:0]   last_paddr [SETS_DEF];
    int                  set_pool [4];
    bit                  no_gaps;

    srdb_in_if  in_ch ();
    srdb_out_if out_ch ();

    ship_rrip_dead_block_replacement dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    srdb_victim_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .in_mon          (in_ch),
        .out_mon         (out_ch),
        .mismatches      (mismatches),
        .victims_pending (victims_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ship_rrip_dead_block_replacement_test: errors");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send(logic op, int set, int way, logic [ADDR_W-1:0] pc,
                        logic [ADDR_W-1:0] paddr, logic hit);
        int n;
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.set_index <= set[SET_W-1:0];
        in_ch.way       <= way[WAY_W-1:0];
        in_ch.pc        <= pc;
        in_ch.paddr     <= paddr;
        in_ch.hit       <= hit;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        n = gap_len();
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic lookup(int set);
        send(OP_VICTIM, set, $urandom_range(0, 15), {$urandom, $urandom},
             {$urandom, $urandom}, 1'($urandom));
    endtask

    task automatic touch(int set, int way, logic [ADDR_W-1:0] pc,
                         logic [ADDR_W-1:0] paddr, logic hit);
        send(OP_UPDATE, set, way, pc, paddr, hit);
        last_paddr[set] = paddr;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (victims_pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_period(logic [PERIOD_W-1:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int                set;
        int                r;
        logic [ADDR_W-1:0] addr;
        for (int i = 0; i < 4; i++)
            set_pool[i] = $urandom_range(0, SETS_DEF - 1);
        set_pool[0] = ($urandom_range(0, 1) == 0) ? 0 : SETS_DEF - 1;
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++)
        begin
            set = ($urandom_range(0, 99) < 85) ? set_pool[$urandom_range(0, 3)]
                                               : $urandom_range(0, SETS_DEF - 1);
            if ($urandom_range(0, 99) < 40)
                lookup(set);
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    addr = ($urandom_range(0, 1) == 0) ? last_paddr[set] + 64
                                                        : last_paddr[set] - 64;
                else if (r < 42)
                    addr = last_paddr[set];
                else
                    addr = {$urandom, $urandom};
                touch(set, $urandom_range(0, 15), {$urandom, $urandom}, addr,
                      ($urandom_range(0, 99) < 45));
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        logic [PERIOD_W-1:0] periods [7];
        periods = '{5'd2, 5'd0, 5'd31, 5'd20, 5'd1, 5'd3, 5'd12};
        cycles          = 0;
        no_gaps         = 1'b0;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.op        <= OP_VICTIM;
        in_ch.set_index <= '0;
        in_ch.way       <= '0;
        in_ch.pc        <= '0;
        in_ch.paddr     <= '0;
        in_ch.hit       <= 1'b0;
        for (int i = 0; i < SETS_DEF; i++)
            last_paddr[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: fresh sets, extremes, dead ways, streaming, aging
        lookup(0);
        lookup(SETS_DEF - 1);
        touch(SETS_DEF - 1, 15, '1, '1, 1'b0);
        touch(0, 0, '0, '0, 1'b0);
        touch(0, 0, 48'h0000_0000_00F0, 48'h0000_0000_0F00, 1'b0);
        touch(0, 0, 48'h0000_0000_00F0, 48'h0000_0000_0F00, 1'b0);
        lookup(0);
        touch(0, 0, '1, '1, 1'b1);
        lookup(0);
        for (int w = 0; w < 16; w++)
            touch(7, w, 48'h0000_0000_0011, 48'h0000_1000_0000 + 64 * w, 1'b1);
        lookup(7);
        touch(9, 3, 48'h1234_5678_9ABC, 48'h0000_0000_4000, 1'b0);
        touch(9, 4, 48'h1234_5678_9ABC, 48'h0000_0000_3FC0, 1'b0);
        touch(9, 5, 48'h1234_5678_9ABC, 48'h0000_0000_4000, 1'b0);
        lookup(9);

        random_phase(60);
        foreach (periods[p])
        begin
            write_period(periods[p]);
            random_phase((periods[p] == 5'd0) ? 40 : 55);
        end

        drain();
        if (mismatches == 0)
            $display("ship_rrip_dead_block_replacement_test: clean");
        else
            $display("ship_rrip_dead_block_replacement_test: errors");
        $finish;
    end

    initial
    begin
        int   r;
        int   n;
        logic level;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                level = 1'b1;
                n = $urandom_range(1, 30);
            end
            else if (r < 90)
            begin
                level = 1'b0;
                n = $urandom_range(1, 4);
            end
            else
            begin
                level = 1'b0;
                n = $urandom_range(15, 60);
            end
            repeat (n)
            begin
                @(posedge clk);
                out_ch.ready <= level;
            end
        end
    end

endmodule
